FILE: src/cfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants of the command frame builder and parser:
// item codes, result kinds, register indexes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package cfb_pkg;

  // Payload store depth default
  localparam int unsigned MAX_PAYLOAD = 32;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned CAP_W   = 6;
  localparam int unsigned CFG_AW  = 1;

  // Configuration register indexes and reset values
  localparam logic [CFG_AW-1:0] REG_START_BYTE  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_CAPTURE_LEN = 1'd1;
  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hAA;
  localparam logic [CAP_W-1:0]  CAPTURE_LEN_RST = 6'd32;

  // Input item codes
  typedef enum logic [OP_W-1:0] {
    OP_BEGIN   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_RXBYTE  = 2'd2,
    OP_IDLE    = 2'd3
  } op_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LINE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  // Source of a pushed result
  typedef enum logic [2:0] {
    SRC_START,
    SRC_CMD,
    SRC_LEN,
    SRC_TXSUM,
    SRC_BYTE,
    SRC_STATUS,
    SRC_MEM
  } src_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input transaction this cycle
    logic push;     // load a result into the output register
    src_e src;      // where the pushed result comes from
    logic last;     // pushed result ends the run
    logic rd_en;    // payload store read
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a result
    logic len_zero;    // latched begin length was zero
    logic tx_open;     // transmit frame open
    logic rx_release;  // next received byte is the checksum
    logic rx_empty;    // nothing stored in this frame
    logic rel_last;    // release index is the last stored entry
  } sts_t;

endpackage

FILE: src/cfb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_ctrl
// Sequencer: takes input transactions while idle and steps through the
// results each one causes, one per cycle when the output register is free.
// ----------------------------------------------------------------------------
module cfb_ctrl import cfb_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD,
  localparam int unsigned SW = $clog2(MaxPayload + 1),
  localparam int unsigned AW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [OP_W-1:0] op_i,
  output logic          in_ready_o,
  input  sts_t          sts_i,
  output cmd_t          cmd_o,
  output logic [SW-1:0] k_o,
  output logic [AW-1:0] rd_addr_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_PAY,
    ST_STATUS,
    ST_PREP,
    ST_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [1:0]    step_q, step_d;
  logic [SW-1:0] k_q, k_d;
  logic          accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign k_o        = k_q;

  // Next state and result selection
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    k_d          = k_q;
    cmd_o        = '0;
    cmd_o.src    = SRC_START;
    cmd_o.accept = accept;
    rd_addr_o    = '0;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        k_d    = '0;
        if (accept) begin
          case (op_e'(op_i))
            OP_BEGIN:   state_d = ST_BEGIN;
            OP_PAYLOAD: if (sts_i.tx_open) state_d = ST_PAY;
            OP_RXBYTE: begin
              if (sts_i.rx_release) state_d = sts_i.rx_empty ? ST_STATUS : ST_PREP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      // Header, then the checksum when the frame has no payload
      ST_BEGIN: begin
        cmd_o.push = sts_i.out_free;
        case (step_q)
          2'd0:    cmd_o.src = SRC_START;
          2'd1:    cmd_o.src = SRC_CMD;
          2'd2:    cmd_o.src = SRC_LEN;
          default: cmd_o.src = SRC_TXSUM;
        endcase
        cmd_o.last = ((step_q == 2'd2) && !sts_i.len_zero) || (step_q == 2'd3);
        if (cmd_o.push) begin
          step_d = step_q + 2'd1;
          if (cmd_o.last) state_d = ST_IDLE;
        end
      end
      // Payload byte, then the checksum when the frame just closed
      ST_PAY: begin
        cmd_o.push = sts_i.out_free;
        cmd_o.src  = (step_q == 2'd0) ? SRC_BYTE : SRC_TXSUM;
        cmd_o.last = (step_q != 2'd0) || sts_i.tx_open;
        if (cmd_o.push) begin
          step_d = step_q + 2'd1;
          if (cmd_o.last) state_d = ST_IDLE;
        end
      end
      ST_STATUS: begin
        cmd_o.push = sts_i.out_free;
        cmd_o.src  = SRC_STATUS;
        cmd_o.last = 1'b1;
        if (cmd_o.push) state_d = ST_IDLE;
      end
      // Fetch the first stored byte
      ST_PREP: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = '0;
        state_d     = ST_EMIT;
      end
      // Release stored bytes, prefetching the next one on each push
      ST_EMIT: begin
        cmd_o.push  = sts_i.out_free;
        cmd_o.src   = SRC_MEM;
        cmd_o.last  = sts_i.rel_last;
        cmd_o.rd_en = cmd_o.push;
        rd_addr_o   = AW'(k_q + SW'(1));
        if (cmd_o.push) begin
          k_d = k_q + SW'(1);
          if (cmd_o.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      k_q     <= k_d;
    end
  end

  // Results are only produced outside idle, and never into a full register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (state_q != ST_IDLE) && sts_i.out_free)
    else $error("result pushed while idle or output register full");

  // A last result always returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push && cmd_o.last |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after last result");

  // A transmit header run never takes more than four results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BEGIN) && (step_q == 2'd3) |-> cmd_o.last)
    else $error("header run overran");

endmodule

FILE: src/cfb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_dp
// Datapath: configuration registers, transmit sum and count, receive parser
// registers, payload store and the output register.
// ----------------------------------------------------------------------------
module cfb_dp import cfb_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD,
  localparam int unsigned SW = $clog2(MaxPayload + 1),
  localparam int unsigned AW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [BYTE_W-1:0] command_i,
  input  logic [BYTE_W-1:0] length_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  cmd_t              cmd_i,
  input  logic [SW-1:0]     k_i,
  input  logic [AW-1:0]     rd_addr_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic [BYTE_W-1:0] byte_out_o,
  output logic [INDEX_W-1:0] index_o,
  output logic              checksum_ok_o,
  output logic              last_o
);

  typedef enum logic [2:0] {
    PH_START,
    PH_CMD,
    PH_COUNT,
    PH_DATA,
    PH_SUM,
    PH_DONE
  } phase_e;

  localparam logic [6:0] MaxP7 = 7'(MaxPayload);

  // Configuration
  logic [BYTE_W-1:0] start_q;
  logic [CAP_W-1:0]  cap_q;

  // Transmit side
  logic [BYTE_W-1:0] tx_sum_q, tx_sum_d;
  logic [BYTE_W-1:0] tx_rem_q, tx_rem_d;
  logic              tx_open_q, tx_open_d;
  logic [BYTE_W-1:0] cmd_q, len_q, byte_q;

  // Receive side
  phase_e            ph_q, ph_d;
  logic [BYTE_W-1:0] rx_cnt_q, rx_cnt_d;
  logic [BYTE_W-1:0] rx_sum_q, rx_sum_d;
  logic [SW-1:0]     rx_stored_q, rx_stored_d;
  logic              ok_q, ok_d;
  logic [6:0]        cap7;
  logic              wr_en;

  // Payload store
  logic [BYTE_W-1:0] mem [MaxPayload];
  logic [BYTE_W-1:0] rd_q;

  // Output register
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [BYTE_W-1:0] obyte_q, obyte_d;
  logic [INDEX_W-1:0] oidx_q, oidx_d;
  logic              ook_q, ook_d;
  logic              olast_q;

  assign cap7 = ({1'b0, cap_q} > MaxP7) ? MaxP7 : {1'b0, cap_q};

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_BYTE_RST;
      cap_q   <= CAPTURE_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_START_BYTE:  start_q <= cfg_wdata_i;
        REG_CAPTURE_LEN: cap_q   <= cfg_wdata_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame state updates on an accepted transaction
  always_comb begin
    tx_sum_d    = tx_sum_q;
    tx_rem_d    = tx_rem_q;
    tx_open_d   = tx_open_q;
    ph_d        = ph_q;
    rx_cnt_d    = rx_cnt_q;
    rx_sum_d    = rx_sum_q;
    rx_stored_d = rx_stored_q;
    ok_d        = ok_q;
    wr_en       = 1'b0;
    if (cmd_i.accept) begin
      case (op_e'(op_i))
        OP_BEGIN: begin
          tx_sum_d  = start_q + command_i + length_i;
          tx_rem_d  = length_i;
          tx_open_d = (length_i != '0);
        end
        OP_PAYLOAD: begin
          if (tx_open_q) begin
            tx_sum_d  = tx_sum_q + data_byte_i;
            tx_rem_d  = tx_rem_q - 8'd1;
            tx_open_d = (tx_rem_q != 8'd1);
          end
        end
        OP_IDLE: begin
          ph_d        = PH_START;
          rx_cnt_d    = '0;
          rx_sum_d    = '0;
          rx_stored_d = '0;
        end
        default: begin
          case (ph_q)
            PH_START: begin
              rx_sum_d = rx_sum_q + data_byte_i;
              ph_d     = PH_CMD;
            end
            PH_CMD: begin
              rx_sum_d = rx_sum_q + data_byte_i;
              ph_d     = PH_COUNT;
            end
            PH_COUNT: begin
              rx_sum_d = rx_sum_q + data_byte_i;
              rx_cnt_d = data_byte_i;
              ph_d     = (data_byte_i == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
              if (7'(rx_stored_q) < cap7) begin
                wr_en       = 1'b1;
                rx_stored_d = rx_stored_q + SW'(1);
              end
              rx_sum_d = rx_sum_q + data_byte_i;
              rx_cnt_d = rx_cnt_q - 8'd1;
              if (rx_cnt_q == 8'd1) ph_d = PH_SUM;
            end
            PH_SUM: begin
              ok_d = (rx_sum_q == data_byte_i);
              ph_d = PH_DONE;
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_sum_q    <= '0;
      tx_rem_q    <= '0;
      tx_open_q   <= 1'b0;
      ph_q        <= PH_START;
      rx_cnt_q    <= '0;
      rx_sum_q    <= '0;
      rx_stored_q <= '0;
      ok_q        <= 1'b0;
    end else begin
      tx_sum_q    <= tx_sum_d;
      tx_rem_q    <= tx_rem_d;
      tx_open_q   <= tx_open_d;
      ph_q        <= ph_d;
      rx_cnt_q    <= rx_cnt_d;
      rx_sum_q    <= rx_sum_d;
      rx_stored_q <= rx_stored_d;
      ok_q        <= ok_d;
    end
  end

  // Latched item fields for the result run
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= command_i;
      len_q  <= length_i;
      byte_q <= data_byte_i;
    end
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[rx_stored_q[AW-1:0]] <= data_byte_i;
    if (cmd_i.rd_en) rd_q <= mem[rd_addr_i];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result fields by source
  always_comb begin
    kind_d  = KIND_LINE;
    obyte_d = '0;
    oidx_d  = '0;
    ook_d   = 1'b0;
    case (cmd_i.src)
      SRC_START: obyte_d = start_q;
      SRC_CMD:   obyte_d = cmd_q;
      SRC_LEN:   obyte_d = len_q;
      SRC_TXSUM: obyte_d = tx_sum_q;
      SRC_BYTE:  obyte_d = byte_q;
      SRC_STATUS: begin
        kind_d = KIND_STATUS;
        ook_d  = ok_q;
      end
      SRC_MEM: begin
        kind_d  = KIND_PAYLOAD;
        obyte_d = ok_q ? rd_q : '0;
        oidx_d  = INDEX_W'(k_i);
        ook_d   = ok_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      kind_q  <= kind_d;
      obyte_q <= obyte_d;
      oidx_q  <= oidx_d;
      ook_q   <= ook_d;
      olast_q <= cmd_i.last;
    end
  end

  // Status to the sequencer
  always_comb begin
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.len_zero   = (len_q == '0);
    sts_o.tx_open    = tx_open_q;
    sts_o.rx_release = (ph_q == PH_SUM);
    sts_o.rx_empty   = (rx_stored_q == '0);
    sts_o.rel_last   = ((SW + 1)'(k_i) + (SW + 1)'(1)) == (SW + 1)'(rx_stored_q);
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign byte_out_o    = obyte_q;
  assign index_o       = oidx_q;
  assign checksum_ok_o = ook_q;
  assign last_o        = olast_q;

  // An open transmit frame always has bytes left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_open_q |-> tx_rem_q != '0)
    else $error("transmit frame open with no bytes left");

  // Store never fills past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    7'(rx_stored_q) <= MaxP7)
    else $error("payload store overfilled");

  // Release only reads entries written in this frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && (cmd_i.src == SRC_MEM) |-> k_i < rx_stored_q)
    else $error("release beyond stored bytes");

  // Nothing is stored before the payload phase of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_START) || (ph_q == PH_CMD) || (ph_q == PH_COUNT) |-> rx_stored_q == '0)
    else $error("stored bytes outside payload phase");

endmodule

FILE: src/command_frame_builder_and_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_builder_and_parser_top
// Serial command frame builder and parser with an 8-bit sum checksum.
//
// Input stream (s_axis): tuser carries the item code (begin frame, send
// payload byte, received line byte, line idle), tdata the command, length
// and data byte. Output stream (m_axis): tuser carries the result kind,
// tdata the byte, payload index and checksum flag, tlast ends each run of
// results caused by one input transaction.
// Configuration: cfg_we_i writes register cfg_addr_i (0 start byte,
// 1 capture length) on the clock edge; write only while the block is idle.
// Timing: an item that causes no result keeps the block idle, so such items
// can follow each other every cycle. An item with results is followed by its
// run, one result per cycle from the sequencer while the output register is
// free; a checksum byte that releases stored bytes first reads the payload
// store, then releases them. A result sits in the output register, so a stall on
// m_axis only holds the sequencer; the next item is taken once a run is
// fully pushed. Reset clears both sides to idle and restores the register
// defaults (start byte 0xAA, capture length 32); the store needs no clear.
// ----------------------------------------------------------------------------
module command_frame_builder_and_parser_top import cfb_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // command[7:0], length[15:8], data_byte[23:16]
  input  logic [OP_W-1:0]   s_axis_tuser,   // op[1:0]
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // byte_out[7:0], index[12:8], checksum_ok[13], 0
  output logic [KIND_W-1:0] m_axis_tuser,   // kind[1:0]
  output logic              m_axis_tlast    // last
);

  localparam int unsigned SW = $clog2(MaxPayload + 1);
  localparam int unsigned AW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic [SW-1:0]     k;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] byte_out;
  logic [INDEX_W-1:0] index;
  logic              checksum_ok;

  cfb_ctrl #(
    .MaxPayload (MaxPayload)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .op_i       (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .k_o        (k),
    .rd_addr_o  (rd_addr)
  );

  cfb_dp #(
    .MaxPayload (MaxPayload)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (s_axis_tuser),
    .command_i     (s_axis_tdata[7:0]),
    .length_i      (s_axis_tdata[15:8]),
    .data_byte_i   (s_axis_tdata[23:16]),
    .cmd_i         (cmd),
    .k_i           (k),
    .rd_addr_i     (rd_addr),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .kind_o        (m_axis_tuser),
    .byte_out_o    (byte_out),
    .index_o       (index),
    .checksum_ok_o (checksum_ok),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, checksum_ok, index, byte_out};

endmodule

FILE: tb/tb_command_frame_builder_and_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_frame_builder_and_parser_top
// Self-checking bench for the command frame builder and parser. Predicts the
// transmit frames (header, payload, sum byte) and the released receive payload
// and status. It drives directed frames, then random well-formed and broken
// frames under several register settings, with bursty input and a stalling
// output side.
// ----------------------------------------------------------------------------
module tb_command_frame_builder_and_parser_top;
  import cfb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 40;    // longer than the longest release run
  localparam int PHASE_ITEMS  = 40;    // transactions with effect per phase
  localparam int LONG_HOLD    = 300;

  // receive-side parser position
  typedef enum logic [2:0] {
    RX_START, RX_CMD, RX_COUNT, RX_DATA, RX_SUM, RX_DONE
  } rx_phase_e;

  // output stall pattern
  typedef enum logic [1:0] {
    RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY
  } stall_mode_e;

  typedef struct {
    op_e        op;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] data_byte;
  } frame_item_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] byte_out;
    logic [4:0] payload_index;
    logic       checksum_ok;
    logic       last;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // Frame predictor and result queue
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [7:0]    start_byte;
    logic [5:0]    capture_len;
    logic [7:0]    tx_sum;
    logic [7:0]    tx_remaining;
    logic          tx_open;
    rx_phase_e     rx_phase;
    logic [7:0]    rx_count;
    logic [7:0]    rx_sum;
    logic [5:0]    rx_stored;
    logic [7:0]    rx_store [MAX_PAYLOAD];
    frame_result_t expected_q [$];
    int            n_items, n_effective, n_errors;
    int            n_line, n_payload, n_status, n_bad_sums;

    function new();
      start_byte   = START_BYTE_RST;
      capture_len  = CAPTURE_LEN_RST;
      tx_sum       = '0;
      tx_remaining = '0;
      tx_open      = 1'b0;
      clear_rx();
    endfunction

    function void clear_rx();
      rx_phase  = RX_START;
      rx_count  = '0;
      rx_sum    = '0;
      rx_stored = '0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] addr, logic [7:0] data);
      if (addr == REG_START_BYTE) start_byte = data;
      else if (addr == REG_CAPTURE_LEN) capture_len = data[5:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void expect_out(kind_e k, logic [7:0] b, logic [4:0] idx, logic ok,
                             logic lst);
      frame_result_t r;
      r.kind          = k;
      r.byte_out      = b;
      r.payload_index = idx;
      r.checksum_ok   = ok;
      r.last          = lst;
      expected_q.push_back(r);
    endfunction

    // Accepted input transaction: advance state, queue its results
    function void note_input(frame_item_t it);
      int   cap;
      logic ok;
      n_items++;
      case (it.op)
        OP_BEGIN: begin
          n_effective++;
          tx_sum       = start_byte + it.command + it.length;
          tx_remaining = it.length;
          tx_open      = 1'b1;
          expect_out(KIND_LINE, start_byte, '0, 1'b0, 1'b0);
          expect_out(KIND_LINE, it.command, '0, 1'b0, 1'b0);
          if (it.length == 8'd0) begin
            expect_out(KIND_LINE, it.length, '0, 1'b0, 1'b0);
            expect_out(KIND_LINE, tx_sum, '0, 1'b0, 1'b1);
            tx_open = 1'b0;
          end else begin
            expect_out(KIND_LINE, it.length, '0, 1'b0, 1'b1);
          end
        end
        OP_PAYLOAD: begin
          if (tx_open) begin
            n_effective++;
            tx_sum       = tx_sum + it.data_byte;
            tx_remaining = tx_remaining - 8'd1;
            if (tx_remaining == 8'd0) begin
              expect_out(KIND_LINE, it.data_byte, '0, 1'b0, 1'b0);
              expect_out(KIND_LINE, tx_sum, '0, 1'b0, 1'b1);
              tx_open = 1'b0;
            end else begin
              expect_out(KIND_LINE, it.data_byte, '0, 1'b0, 1'b1);
            end
          end
        end
        OP_IDLE: clear_rx();
        default: begin
          if (rx_phase != RX_DONE) n_effective++;
          case (rx_phase)
            RX_START: begin
              rx_sum   = rx_sum + it.data_byte;
              rx_phase = RX_CMD;
            end
            RX_CMD: begin
              rx_sum   = rx_sum + it.data_byte;
              rx_phase = RX_COUNT;
            end
            RX_COUNT: begin
              rx_sum   = rx_sum + it.data_byte;
              rx_count = it.data_byte;
              rx_phase = (it.data_byte == 8'd0) ? RX_SUM : RX_DATA;
            end
            RX_DATA: begin
              cap = (capture_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(capture_len);
              if (rx_stored < cap) begin
                rx_store[rx_stored] = it.data_byte;
                rx_stored           = rx_stored + 6'd1;
              end
              rx_sum   = rx_sum + it.data_byte;
              rx_count = rx_count - 8'd1;
              if (rx_count == 8'd0) rx_phase = RX_SUM;
            end
            RX_SUM: begin
              ok       = (rx_sum == it.data_byte);
              rx_phase = RX_DONE;
              if (!ok) n_bad_sums++;
              if (rx_stored == 6'd0) begin
                expect_out(KIND_STATUS, 8'h00, '0, ok, 1'b1);
              end else begin
                for (int k = 0; k < rx_stored; k++) begin
                  expect_out(KIND_PAYLOAD, ok ? rx_store[k] : 8'h00, 5'(k), ok,
                             k == rx_stored - 1);
                end
              end
            end
            default: ;  // bytes after the sum byte wait for idle
          endcase
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        n_errors++;
      end
    endfunction

    // Accepted output transaction against the oldest expectation
    function void check_result(logic [KIND_W-1:0] kind_bits, logic [15:0] data,
                               logic last_bit);
      frame_result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d, tdata 0x%04h, tlast %0b",
               kind_bits, data, last_bit);
        n_errors++;
        return;
      end
      r = expected_q.pop_front();
      case (r.kind)
        KIND_LINE:    n_line++;
        KIND_PAYLOAD: n_payload++;
        default:      n_status++;
      endcase
      compare_field("kind", r.kind, kind_bits);
      compare_field("byte_out", r.byte_out, data[7:0]);
      compare_field("index", r.payload_index, data[12:8]);
      compare_field("checksum_ok", r.checksum_ok, data[13]);
      compare_field("last", r.last, last_bit);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i    = '0;
  logic [BYTE_W-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;
  logic [OP_W-1:0]   s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic              m_axis_tlast;

  command_frame_builder_and_parser_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  frame_scoreboard board = new();
  frame_item_t     stim_q [$];
  int              burst_left = 0;
  int              cycle_cnt = 0;
  int              results_seen = 0;
  int              hold_left = 0;
  int              holds_done = 0;
  int              mode_left = 0;
  stall_mode_e     rdy_mode = RDY_ALWAYS;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               board.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Output side: check accepted transactions, stall on its own pattern
  always @(posedge clk_i) begin
    logic ready_next;
    if (m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      results_seen++;
    end
    // two long hold-offs so the block backs up into its input
    if ((holds_done == 0 && results_seen >= 30) ||
        (holds_done == 1 && results_seen >= 250)) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (mode_left == 0) begin
      rdy_mode  = stall_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(10, 80);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      case (rdy_mode)
        RDY_ALWAYS: ready_next = 1'b1;
        RDY_MOSTLY: ready_next = ($urandom_range(0, 3) != 0);
        default:    ready_next = ($urandom_range(0, 3) == 0);
      endcase
    end
    m_axis_tready <= ready_next;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic void add_item(op_e op, logic [7:0] cmd, logic [7:0] len,
                                   logic [7:0] data);
    frame_item_t it;
    it.op        = op;
    it.command   = cmd;
    it.length    = len;
    it.data_byte = data;
    stim_q.push_back(it);
  endfunction

  // Begin item and its payload; sometimes cut short or followed by a stray payload
  function automatic void queue_tx_frame();
    logic [7:0] len;
    int         n_pay;
    len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(0, 6));
    add_item(OP_BEGIN, rnd_byte(), len, rnd_byte());
    if (len > 8'd6) n_pay = $urandom_range(0, 3);
    else if (len != 8'd0 && $urandom_range(0, 5) == 0) n_pay = int'(len) - 1;
    else n_pay = int'(len);
    for (int i = 0; i < n_pay; i++) add_item(OP_PAYLOAD, rnd_byte(), rnd_byte(), rnd_byte());
    if ($urandom_range(0, 5) == 0) add_item(OP_PAYLOAD, rnd_byte(), rnd_byte(), rnd_byte());
  endfunction

  // Line frame with a mostly correct sum byte, optional trailing bytes
  function automatic void queue_rx_frame();
    logic [7:0] sum, b, cnt;
    if ($urandom_range(0, 9) != 0) add_item(OP_IDLE, rnd_byte(), rnd_byte(), rnd_byte());
    b   = ($urandom_range(0, 3) == 0) ? rnd_byte() : board.start_byte;
    sum = b;
    add_item(OP_RXBYTE, rnd_byte(), rnd_byte(), b);
    b   = rnd_byte();
    sum = sum + b;
    add_item(OP_RXBYTE, rnd_byte(), rnd_byte(), b);
    cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(20, 40))
                                      : 8'($urandom_range(0, 6));
    sum = sum + cnt;
    add_item(OP_RXBYTE, rnd_byte(), rnd_byte(), cnt);
    for (int i = 0; i < cnt; i++) begin
      b   = rnd_byte();
      sum = sum + b;
      add_item(OP_RXBYTE, rnd_byte(), rnd_byte(), b);
    end
    if ($urandom_range(0, 3) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    add_item(OP_RXBYTE, rnd_byte(), rnd_byte(), sum);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) add_item(OP_RXBYTE, rnd_byte(), rnd_byte(), rnd_byte());
    end
  endfunction

  function automatic void queue_noise();
    repeat ($urandom_range(1, 3)) begin
      add_item(op_e'($urandom_range(0, 3)), rnd_byte(), rnd_byte(), rnd_byte());
    end
  endfunction

  // One input transaction; valid stays high for a following item
  task automatic send_item(input frame_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.data_byte, it.length, it.command};
    s_axis_tuser  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(it);
  endtask

  // Send the queue in bursts with random gaps
  task automatic drive_queued();
    frame_item_t it;
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      send_item(it);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] start_val, input logic [5:0] cap_val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_START_BYTE;
    cfg_wdata_i <= start_val;
    @(posedge clk_i);
    cfg_addr_i  <= REG_CAPTURE_LEN;
    cfg_wdata_i <= {2'b00, cap_val};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.write_reg(REG_START_BYTE, start_val);
    board.write_reg(REG_CAPTURE_LEN, {2'b00, cap_val});
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int         phase_base;
    int         pick;
    logic [7:0] start_val;
    logic [5:0] cap_val;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: transmit frames
    add_item(OP_BEGIN,   8'h00, 8'd0,   8'h00);  // zero length: header then sum
    add_item(OP_BEGIN,   8'hFF, 8'd3,   8'h00);
    add_item(OP_PAYLOAD, 8'h00, 8'h00,  8'hFF);
    add_item(OP_PAYLOAD, 8'h00, 8'h00,  8'h00);
    add_item(OP_PAYLOAD, 8'h00, 8'h00,  8'h80);
    add_item(OP_PAYLOAD, 8'h00, 8'h00,  8'h12);  // no open frame
    add_item(OP_BEGIN,   8'h5A, 8'd200, 8'h00);
    add_item(OP_BEGIN,   8'hA5, 8'd1,   8'h00);  // drops the open frame
    add_item(OP_PAYLOAD, 8'h00, 8'h00,  8'hFE);
    // directed: good frame with two payload bytes, then a trailing byte
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'hAA);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h10);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h02);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'hDE);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'hAD);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h47);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h55);
    add_item(OP_IDLE,   8'hFF, 8'hFF, 8'hFF);
    // bad sum: payload comes back zeroed
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h00);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'hFF);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h01);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h77);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h00);
    add_item(OP_IDLE,   8'h00, 8'h00, 8'h00);
    // empty frame with an unmatched start byte: status only
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'hFF);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h00);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'h00);
    add_item(OP_RXBYTE, 8'h00, 8'h00, 8'hFF);
    drive_queued();

    // random phases, one register setting each
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0:       begin start_val = 8'h00;      cap_val = 6'd0;  end
        1:       begin start_val = 8'hFF;      cap_val = 6'd32; end
        2:       begin start_val = rnd_byte(); cap_val = 6'($urandom_range(2, 5)); end
        default: begin start_val = rnd_byte(); cap_val = 6'd1;  end
      endcase
      write_regs(start_val, cap_val);
      phase_base = board.n_effective;
      while (board.n_effective - phase_base < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) queue_rx_frame();
        else if (pick < 17) queue_tx_frame();
        else queue_noise();
        drive_queued();
      end
    end

    wait_idle();
    $display("covered %0d input transactions (%0d with effect) over 5 register settings",
             board.n_items, board.n_effective);
    $display("checked %0d line bytes, %0d payload bytes, %0d status words; %0d bad sums",
             board.n_line, board.n_payload, board.n_status, board.n_bad_sums);
    if (board.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cfb_pkg.sv
src/cfb_ctrl.sv
src/cfb_dp.sv
src/command_frame_builder_and_parser_top.sv
tb/tb_command_frame_builder_and_parser_top.sv
